// File: hdl/probabilistic_bit_update_macros.svh
// assertion helpers shared by the p-bit update block
`ifndef PROBABILISTIC_BIT_UPDATE_MACROS_SVH
`define PROBABILISTIC_BIT_UPDATE_MACROS_SVH

// same-cycle implication
`define PBU_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/pbu_pkg.sv
`timescale 1ns / 1ps

package pbu_pkg;

   // bit position of the updated bit
   localparam int BIT_POSITION_DEFAULT = 4;

   // channel widths
   localparam int SUM_W       = 32;
   localparam int RAND_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // accumulator and attenuation
   localparam int ACC_FRAC    = 24;
   localparam int ACC_W       = ACC_FRAC + 1;
   localparam int REM_W       = ACC_FRAC + 2;
   localparam int CAP_W       = 40;
   localparam int LIM_W       = 15;
   localparam int FOUT_W      = LIM_W + 1;
   localparam int REM_SMALL_W = 15;
   localparam longint FIELD_CAP = (longint'(1) << (CAP_W - 1)) - 1;

   // threshold table
   localparam int RMOD_W    = 12;
   localparam int RAND_MOD  = 2049;
   localparam int SIG_SPAN  = 2048;
   localparam int SIG_MAX   = 127;
   localparam int SIG_MIN   = -128;
   localparam int CUT_COUNT = 2 * SIG_MAX + 1;
   localparam int CUT_IDX_W = 8;
   localparam int CUT_W     = 11;
   localparam logic [63:0] K_LN16 = 64'd47632711549;

   // mode flag bits
   localparam int MODE_SUPPRESS = 0;
   localparam int MODE_POLARITY = 1;
   localparam int MODE_POWER    = 2;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMP_SHIFT_A  = 3'd0,
      CSR_TEMP_SHIFT_B  = 3'd1,
      CSR_TEMP_SHIFT_C  = 3'd2,
      CSR_DECAY_SHIFT_A = 3'd3,
      CSR_DECAY_SHIFT_B = 3'd4,
      CSR_REGION_SHIFT  = 3'd5,
      CSR_CLAMP_LIMIT   = 3'd6,
      CSR_MODE_FLAGS    = 3'd7
   } csr_index_type;

   // transition codes
   typedef enum logic [1:0] {
      TR_ROSE = 2'd0,
      TR_SAME = 2'd1,
      TR_FELL = 2'd2
   } transition_type;

   typedef struct packed {
      logic [5:0]       temp_shift_a;
      logic [5:0]       temp_shift_b;
      logic [5:0]       temp_shift_c;
      logic [4:0]       decay_shift_a;
      logic [4:0]       decay_shift_b;
      logic [4:0]       region_shift;
      logic [LIM_W-1:0] clamp_limit;
      logic [2:0]       mode_flags;
   } cfg_type;

   typedef struct packed {
      logic             new_bit;
      transition_type   transition;
      logic [ACC_W-1:0] acc_next;
   } step_type;

   localparam cfg_type CFG_RESET = '{
      temp_shift_a:  6'd8,
      temp_shift_b:  6'd9,
      temp_shift_c:  6'd10,
      decay_shift_a: 5'd6,
      decay_shift_b: 5'd8,
      region_shift:  5'd2,
      clamp_limit:   15'd127,
      mode_flags:    3'd0
   };

   // log2 in Q32 by repeated squaring, for 1 <= v < 2^12
   function automatic logic [63:0] log2_q32(input logic [11:0] v);
      logic [63:0] m;
      logic [63:0] r;
      int          e;
      int          i;
      e = 0;
      for (i = 0; i < 12; i++) begin
         if (v[i]) begin
            e = i;
         end
      end
      m = 64'(v) << (31 - e);
      r = 64'(e) << 32;
      for (i = 31; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m    = m >> 1;
            r[i] = 1'b1;
         end
      end
      return r;
   endfunction

   // trunc(16*ln(2048/r - 1)) clamped, for r in 0..2048
   function automatic int sigmoid_code(input int r);
      logic [11:0] a;
      logic [11:0] b;
      logic [11:0] tmp;
      logic [63:0] t;
      logic [63:0] q;
      logic        neg;
      int          res;
      neg = 1'b0;
      if (r == 0) begin
         res = SIG_MAX;
      end else if (r == SIG_SPAN) begin
         res = SIG_MIN;
      end else begin
         a = 12'(SIG_SPAN - r);
         b = 12'(r);
         if (a < b) begin
            tmp = a;
            a   = b;
            b   = tmp;
            neg = 1'b1;
         end
         t = log2_q32(a) - log2_q32(b);
         q = t * (K_LN16 >> 16) + ((t * (K_LN16 & 64'hFFFF)) >> 16);
         q = q >> 48;
         if (q > 64'(SIG_MAX)) begin
            q = 64'(SIG_MAX);
         end
         res = neg ? -int'(q) : int'(q);
      end
      return res;
   endfunction

   // for each compare value v, the largest r whose code is still >= v
   typedef logic [CUT_COUNT-1:0][CUT_W-1:0] cut_table_type;

   function automatic cut_table_type build_cuts();
      cut_table_type cuts;
      int            idx;
      int            step;
      int            lo;
      int            hi;
      int            mid;
      for (idx = 0; idx < CUT_COUNT; idx++) begin
         lo = 0;
         hi = SIG_SPAN;
         for (step = 0; step < CUT_W; step++) begin
            mid = (lo + hi) >> 1;
            if (sigmoid_code(mid) >= idx - SIG_MAX) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         cuts[idx] = CUT_W'(lo);
      end
      return cuts;
   endfunction

   localparam cut_table_type CUT_TABLE = build_cuts();

endpackage

// File: hdl/pbu_req_if.sv
`timescale 1ns / 1ps

interface pbu_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pbu_pkg::SUM_W-1:0]  cross_sum;
   logic signed [pbu_pkg::SUM_W-1:0]  square_sum;
   logic        [pbu_pkg::RAND_W-1:0] random_value;

   modport source (output valid, output cross_sum, output square_sum, output random_value,
                   input ready);
   modport sink (input valid, input cross_sum, input square_sum, input random_value,
                 output ready);
endinterface

// File: hdl/pbu_rsp_if.sv
`timescale 1ns / 1ps

interface pbu_rsp_if;
   logic       valid;
   logic       ready;
   logic       new_bit;
   logic [1:0] transition;

   modport source (output valid, output new_bit, output transition, input ready);
   modport sink (input valid, input new_bit, input transition, output ready);
endinterface

// File: hdl/pbu_csr_if.sv
`timescale 1ns / 1ps

interface pbu_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [pbu_pkg::CSR_INDEX_W-1:0]       reg_index;
   logic [pbu_pkg::CSR_DATA_W-1:0]        write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// File: hdl/pbu_datapath.sv
`timescale 1ns / 1ps

module pbu_datapath #(
   parameter int BIT_POSITION = pbu_pkg::BIT_POSITION_DEFAULT
) (
   input  logic signed [pbu_pkg::SUM_W-1:0]  cross_sum,
   input  logic signed [pbu_pkg::SUM_W-1:0]  square_sum,
   input  logic        [pbu_pkg::RAND_W-1:0] random_value,
   input  logic                              old_bit,
   input  logic        [pbu_pkg::ACC_W-1:0]  acc,
   input  pbu_pkg::cfg_type                  cfg,
   output pbu_pkg::step_type                 step
);

   localparam int ACC_W   = pbu_pkg::ACC_W;
   localparam int ACC_FRAC = pbu_pkg::ACC_FRAC;
   localparam int REM_W   = pbu_pkg::REM_W;
   localparam int CAP_W   = pbu_pkg::CAP_W;
   localparam int FOUT_W  = pbu_pkg::FOUT_W;
   localparam int S1_SH   = BIT_POSITION + 1;
   localparam int S2_SH   = 2 * BIT_POSITION;
   localparam int MAX_SH  = (S1_SH > S2_SH) ? S1_SH : S2_SH;
   localparam int FW      = pbu_pkg::SUM_W + MAX_SH + 1;
   localparam int SW      = FW + 2;
   localparam int CW      = (SW > CAP_W) ? SW : CAP_W;
   localparam int PA_W    = ACC_FRAC + REM_W;
   localparam int PB_W    = (CAP_W - 1) + pbu_pkg::REM_SMALL_W;
   localparam int ATT_W   = PB_W - ACC_FRAC;
   localparam int SUMA_W  = ACC_W + 3;

   localparam logic signed [CW-1:0]      CAP_POS = CW'(pbu_pkg::FIELD_CAP);
   localparam logic signed [CW-1:0]      CAP_NEG = -CAP_POS;
   localparam logic signed [SUMA_W-1:0]  SUM_MAX = SUMA_W'((longint'(1) << ACC_FRAC) - 1);
   localparam logic signed [SUMA_W-1:0]  SUM_MIN = SUMA_W'(-(longint'(1) << ACC_FRAC));
   localparam logic signed [ACC_W+1:0]   ACC_ONE = (ACC_W + 2)'(longint'(1) << ACC_FRAC);
   localparam logic signed [FOUT_W-1:0]  SIG_HI  = FOUT_W'(pbu_pkg::SIG_MAX);
   localparam logic signed [FOUT_W-1:0]  SIG_LO  = FOUT_W'(-pbu_pkg::SIG_MAX);
   localparam logic signed [pbu_pkg::RMOD_W:0] MOD_ADD = (pbu_pkg::RMOD_W + 1)'(pbu_pkg::RAND_MOD);

   // temperature shift below four means no shift
   function automatic logic [5:0] temp_amount(input logic [5:0] v);
      return (v < 6'd4) ? 6'd0 : v - 6'd4;
   endfunction

   // decay shift saturated into 1..24
   function automatic logic [4:0] decay_amount(input logic [4:0] v);
      logic [4:0] res;
      if (v == 5'd0) begin
         res = 5'd1;
      end else if (v > 5'(ACC_FRAC)) begin
         res = 5'(ACC_FRAC);
      end else begin
         res = v;
      end
      return res;
   endfunction

   logic signed [FW-1:0]       s1;
   logic signed [FW-1:0]       s2;
   logic signed [FW-1:0]       field;
   logic signed [SW-1:0]       scaled;
   logic signed [CW-1:0]       wide;
   logic signed [CAP_W-1:0]    f40;
   logic [4:0]                 da;
   logic [4:0]                 db;
   logic [ACC_W-1:0]           base;
   logic [ACC_W-1:0]           part;
   logic signed [ACC_W+1:0]    inj;
   logic                       inject_on;
   logic signed [ACC_W-1:0]    acc_s;
   logic signed [SUMA_W-1:0]   acc_sum;
   logic signed [ACC_W-1:0]    acc_next;
   logic signed [ACC_W+1:0]    rem_s;
   logic [REM_W-1:0]           rem;
   logic [4:0]                 rem_log;
   logic signed [CAP_W:0]      pow_f;
   logic signed [CAP_W:0]      lim_wide;
   logic signed [FOUT_W-1:0]   lim_s;
   logic signed [FOUT_W-1:0]   pow_cl;
   logic signed [CAP_W-1:0]    f_abs;
   logic [CAP_W-2:0]           mag;
   logic [PA_W-1:0]            prod_a;
   logic [PB_W-1:0]            prod_b;
   logic [ATT_W-1:0]           att;
   logic                       att_over;
   logic [pbu_pkg::LIM_W-1:0]  mul_mag;
   logic signed [FOUT_W-1:0]   mul_cl;
   logic signed [FOUT_W-1:0]   f_fin;
   logic signed [FOUT_W-1:0]   idx_w;
   logic [pbu_pkg::CUT_IDX_W-1:0] cut_idx;
   logic [pbu_pkg::CUT_W-1:0]  cut;
   logic signed [pbu_pkg::RMOD_W:0] r_diff;
   logic [pbu_pkg::RMOD_W-1:0] r_mod;
   logic                       new_bit;

   // field from both sums, sign chosen by the current bit
   always_comb begin
      s1    = FW'(cross_sum) <<< S1_SH;
      s2    = FW'(square_sum) <<< S2_SH;
      field = old_bit ? (s1 + s2) : (s1 - s2);
   end

   // temperature scaling and saturation of the field
   always_comb begin
      scaled = SW'(field >>> temp_amount(cfg.temp_shift_a)) +
               SW'(field >>> temp_amount(cfg.temp_shift_b)) +
               SW'(field >>> temp_amount(cfg.temp_shift_c));
      wide = CW'(scaled);
      if (wide > CAP_POS) begin
         f40 = CAP_POS[CAP_W-1:0];
      end else if (wide < CAP_NEG) begin
         f40 = CAP_NEG[CAP_W-1:0];
      end else begin
         f40 = wide[CAP_W-1:0];
      end
   end

   // suppression accumulator decay and injection
   always_comb begin
      da        = decay_amount(cfg.decay_shift_a);
      db        = decay_amount(cfg.decay_shift_b);
      base      = (ACC_W'(1) << (5'(ACC_FRAC) - da)) + (ACC_W'(1) << (5'(ACC_FRAC) - db));
      part      = base >> cfg.region_shift;
      inj       = $signed({2'b00, base}) - $signed({1'b0, part, 1'b0});
      inject_on = cfg.mode_flags[pbu_pkg::MODE_POLARITY] ? old_bit : !old_bit;
      acc_s     = $signed(acc);
      acc_sum   = SUMA_W'(acc_s) - SUMA_W'(acc_s >>> da) - SUMA_W'(acc_s >>> db) +
                  (inject_on ? SUMA_W'(inj) : SUMA_W'(0));
      if (!cfg.mode_flags[pbu_pkg::MODE_SUPPRESS]) begin
         acc_next = '0;
      end else if (acc_sum > SUM_MAX) begin
         acc_next = SUM_MAX[ACC_W-1:0];
      end else if (acc_sum < SUM_MIN) begin
         acc_next = SUM_MIN[ACC_W-1:0];
      end else begin
         acc_next = acc_sum[ACC_W-1:0];
      end
      rem_s = ACC_ONE - (ACC_W + 2)'(acc_next);
      rem   = rem_s[REM_W-1:0];
   end

   // power-of-two attenuation from the leading one of the remainder
   always_comb begin
      rem_log = '0;
      for (int i = 0; i < REM_W; i++) begin
         if (rem[i]) begin
            rem_log = 5'(i);
         end
      end
      lim_s    = $signed({1'b0, cfg.clamp_limit});
      lim_wide = (CAP_W + 1)'(lim_s);
      if (rem_log == 5'(ACC_FRAC + 1)) begin
         pow_f = (CAP_W + 1)'(f40) <<< 1;
      end else if (rem_log == 5'(ACC_FRAC)) begin
         pow_f = (CAP_W + 1)'(f40);
      end else begin
         pow_f = (CAP_W + 1)'(f40 >>> (5'(ACC_FRAC) - rem_log));
      end
      if (pow_f > lim_wide) begin
         pow_cl = lim_s;
      end else if (pow_f < -lim_wide) begin
         pow_cl = -lim_s;
      end else begin
         pow_cl = pow_f[FOUT_W-1:0];
      end
   end

   // multiply attenuation on the magnitude, split by operand range;
   // a large field against a large remainder always exceeds the clamp
   always_comb begin
      f_abs    = f40[CAP_W-1] ? -f40 : f40;
      mag      = f_abs[CAP_W-2:0];
      prod_a   = PA_W'(mag[ACC_FRAC-1:0]) * PA_W'(rem);
      prod_b   = PB_W'(mag) * PB_W'(rem[pbu_pkg::REM_SMALL_W-1:0]);
      att_over = 1'b0;
      if ((mag >> ACC_FRAC) == '0) begin
         att = ATT_W'(prod_a >> ACC_FRAC);
      end else if ((rem >> pbu_pkg::REM_SMALL_W) == '0) begin
         att = prod_b[PB_W-1:ACC_FRAC];
      end else begin
         att      = '0;
         att_over = 1'b1;
      end
      if (att_over || (att > ATT_W'(cfg.clamp_limit))) begin
         mul_mag = cfg.clamp_limit;
      end else begin
         mul_mag = att[pbu_pkg::LIM_W-1:0];
      end
      mul_cl = f40[CAP_W-1] ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
      f_fin  = cfg.mode_flags[pbu_pkg::MODE_POWER] ? pow_cl : mul_cl;
   end

   // random value mod 2049, using 2048 = -1
   always_comb begin
      r_diff = $signed({2'b00, random_value[10:0]}) -
               $signed({8'b0, random_value[pbu_pkg::RAND_W-1:11]});
      r_mod  = r_diff[pbu_pkg::RMOD_W] ? pbu_pkg::RMOD_W'(r_diff + MOD_ADD)
                                       : r_diff[pbu_pkg::RMOD_W-1:0];
   end

   // compare against the inverse sigmoid through the cut table
   always_comb begin
      idx_w   = f_fin + SIG_HI;
      cut_idx = idx_w[pbu_pkg::CUT_IDX_W-1:0];
      cut     = pbu_pkg::CUT_TABLE[cut_idx];
      if (f_fin > SIG_HI) begin
         new_bit = 1'b1;
      end else if (f_fin < SIG_LO) begin
         new_bit = 1'b0;
      end else begin
         new_bit = (pbu_pkg::RMOD_W'(cut) < r_mod);
      end
   end

   // result and next state
   always_comb begin
      step.new_bit  = new_bit;
      step.acc_next = acc_next;
      if (new_bit == old_bit) begin
         step.transition = pbu_pkg::TR_SAME;
      end else if (new_bit) begin
         step.transition = pbu_pkg::TR_ROSE;
      end else begin
         step.transition = pbu_pkg::TR_FELL;
      end
   end

endmodule

// File: hdl/probabilistic_bit_update.sv
// channel  dir  handshake    payload
// -------  ---  -----------  ------------------------------------------------------
// req_ch   in   valid/ready  cross_sum[31:0] signed, square_sum[31:0] signed,
//                            random_value[15:0]
// rsp_ch   out  valid/ready  new_bit, transition[1:0] (0 rose, 1 same, 2 fell)
// csr_ch   in   valid/ready  reg_index[2:0], write_data[15:0]; always ready
//
// One transaction per cycle while rsp_ch is ready; a request passes the input register,
// then the result register. The rate is set by the bit and accumulator feedback through
// the combinational datapath between the input register and the result register.
// Synchronous reset clears bit, accumulator, both valid flags; config gets defaults.
// A stalled result holds while the input register keeps taking one more transaction.
`timescale 1ns / 1ps
`include "probabilistic_bit_update_macros.svh"

module probabilistic_bit_update #(
   parameter int BIT_POSITION = pbu_pkg::BIT_POSITION_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   pbu_req_if.sink    req_ch,
   pbu_rsp_if.source  rsp_ch,
   pbu_csr_if.sink    csr_ch
);

   pbu_pkg::cfg_type                  cfg_ff;
   logic                              in_valid_ff;
   logic signed [pbu_pkg::SUM_W-1:0]  cross_ff;
   logic signed [pbu_pkg::SUM_W-1:0]  square_ff;
   logic        [pbu_pkg::RAND_W-1:0] random_ff;
   logic                              bit_ff;
   logic        [pbu_pkg::ACC_W-1:0]  acc_ff;
   logic                              out_valid_ff;
   logic                              out_bit_ff;
   pbu_pkg::transition_type           out_tr_ff;
   pbu_pkg::step_type                 step;
   logic                              advance;
   logic                              in_ready;

   // input register moves forward when the result register is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign in_ready = !in_valid_ff || advance;

   assign req_ch.ready      = in_ready;
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.new_bit    = out_bit_ff;
   assign rsp_ch.transition = out_tr_ff;

   pbu_datapath #(
      .BIT_POSITION (BIT_POSITION)
   ) u_datapath (
      .cross_sum    (cross_ff),
      .square_sum   (square_ff),
      .random_value (random_ff),
      .old_bit      (bit_ff),
      .acc          (acc_ff),
      .cfg          (cfg_ff),
      .step         (step)
   );

   // control state, bit state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= pbu_pkg::CFG_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bit_ff       <= 1'b0;
         acc_ff       <= '0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            bit_ff       <= step.new_bit;
            acc_ff       <= step.acc_next;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_ch.valid) begin
            unique case (pbu_pkg::csr_index_type'(csr_ch.reg_index))
               pbu_pkg::CSR_TEMP_SHIFT_A:  cfg_ff.temp_shift_a  <= csr_ch.write_data[5:0];
               pbu_pkg::CSR_TEMP_SHIFT_B:  cfg_ff.temp_shift_b  <= csr_ch.write_data[5:0];
               pbu_pkg::CSR_TEMP_SHIFT_C:  cfg_ff.temp_shift_c  <= csr_ch.write_data[5:0];
               pbu_pkg::CSR_DECAY_SHIFT_A: cfg_ff.decay_shift_a <= csr_ch.write_data[4:0];
               pbu_pkg::CSR_DECAY_SHIFT_B: cfg_ff.decay_shift_b <= csr_ch.write_data[4:0];
               pbu_pkg::CSR_REGION_SHIFT:  cfg_ff.region_shift  <= csr_ch.write_data[4:0];
               pbu_pkg::CSR_CLAMP_LIMIT: begin
                  cfg_ff.clamp_limit <= csr_ch.write_data[pbu_pkg::LIM_W-1:0];
               end
               pbu_pkg::CSR_MODE_FLAGS:    cfg_ff.mode_flags    <= csr_ch.write_data[2:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_ready && req_ch.valid) begin
         cross_ff  <= req_ch.cross_sum;
         square_ff <= req_ch.square_sum;
         random_ff <= req_ch.random_value;
      end
      if (advance) begin
         out_bit_ff <= step.new_bit;
         out_tr_ff  <= step.transition;
      end
   end

   // accumulator is forced to zero by every advance made while suppression is off
   `PBU_ASSERT_NEXT(a_acc_cleared, clock, reset, advance && !cfg_ff.mode_flags[pbu_pkg::MODE_SUPPRESS], acc_ff == '0, "accumulator not cleared with suppression off")

   // delivered bit and stored bit agree
   `PBU_ASSERT_NEXT(a_bit_matches_result, clock, reset, advance, rsp_ch.valid && (rsp_ch.new_bit == bit_ff), "stored bit differs from result")

   // transition code agrees with the change of the stored bit
   `PBU_ASSERT_NEXT(a_transition_code, clock, reset, advance, (rsp_ch.transition == pbu_pkg::TR_SAME) == (bit_ff == $past(bit_ff)), "transition code inconsistent with bit change")

endmodule
